// File: src/lppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types, constants and the magic table for the pack deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

  localparam int unsigned HeaderBytes = 12;
  localparam int unsigned LenBytes    = 4;
  localparam logic [31:0] GoodVersion = 32'd1;

  typedef enum logic [1:0] {
    KIND_LENGTH  = 2'd0,
    KIND_NAME    = 2'd1,
    KIND_DATA    = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_PARSING     = 3'd0,
    ST_DONE        = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_TRUNCATED   = 3'd4
  } status_t;

  // Expected header magic, the characters P, M, S and H in stream order.
  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] m;
    case (idx)
      2'd0:    m = 8'h50;
      2'd1:    m = 8'h4D;
      2'd2:    m = 8'h53;
      default: m = 8'h48;
    endcase
    return m;
  endfunction

endpackage

// File: src/lppd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_in_if
// Valid/ready channel that carries raw pack bytes into the deframer.
// ----------------------------------------------------------------------------
interface lppd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pack_byte;
  logic       start_of_pack;

  modport source (output valid, output pack_byte, output start_of_pack, input ready);
  modport sink   (input valid, input pack_byte, input start_of_pack, output ready);
endinterface

// File: src/lppd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_out_if
// Valid/ready channel that carries tagged bytes out of the deframer.
// ----------------------------------------------------------------------------
interface lppd_out_if;
  logic              valid;
  logic              ready;
  lppd_pkg::kind_t   byte_kind;
  logic [7:0]        payload_byte;
  logic [31:0]       entry_number;
  logic              entry_complete;
  lppd_pkg::status_t parse_status;

  modport source (output valid, output byte_kind, output payload_byte, output entry_number,
                  output entry_complete, output parse_status, input ready);
  modport sink   (input valid, input byte_kind, input payload_byte, input entry_number,
                  input entry_complete, input parse_status, output ready);
endinterface

// File: src/length_prefixed_pack_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_pack_deframer_core
// Byte-wide parser that tags every word of a length-prefixed pack image.
// ----------------------------------------------------------------------------
// Each word on pack_in is one byte of a pack image. The block checks the
// 12-byte header (magic PMSH, little-endian version 1, little-endian entry
// count) and then walks the entries, each a 32-bit name length, the name, a
// 32-bit data length and the data. Every byte comes out once on result_out,
// tagged as length/header, name, data or ignored, with its entry number, a
// flag on the byte that completes an entry and the parse status after it.
// A byte with start_of_pack set restarts the parser; after reset the first
// byte is taken as the start of a pack anyway. Any length that would run
// past pack_size stops the parse with status truncated, so the partial entry
// never completes and can be discarded downstream. pack_size is read live and
// is only to be written while no word is in flight.
// Throughput is one byte per clock and each tagged byte is registered in the
// cycle after it is accepted: the whole per-byte decision (phase update, a
// few 33-bit adds and compares against pack_size and some counter compares)
// sits between the input handshake and the result register, and a new byte
// is taken whenever the result register is empty or being drained.
// ----------------------------------------------------------------------------
module length_prefixed_pack_deframer_core (
  input  logic        clk,
  input  logic        rst,
  lppd_in_if.sink     pack_in,
  lppd_out_if.source  result_out,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);
  import lppd_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_NAMELEN = 3'd1,
    PH_NAME    = 3'd2,
    PH_DATALEN = 3'd3,
    PH_DATA    = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  // Parser state.
  phase_t      phase_q;
  logic [31:0] field_cnt_q;
  logic [31:0] len_acc_q;
  logic [31:0] stream_pos_q;
  logic [31:0] declared_q;
  logic [31:0] finished_q;
  status_t     status_q;
  logic [31:0] pack_size;

  // Result register.
  logic        result_valid;
  kind_t       res_kind;
  logic [7:0]  res_byte;
  logic [31:0] res_entry;
  logic        res_complete;
  status_t     res_status;

  // State as seen by the current word, after an optional restart.
  phase_t      phase_cur;
  logic [31:0] field_cnt_cur;
  logic [31:0] len_acc_cur;
  logic [31:0] stream_pos_cur;
  logic [31:0] declared_cur;
  logic [31:0] finished_cur;
  status_t     status_cur;

  phase_t      phase_next;
  logic [31:0] field_cnt_next;
  logic [31:0] len_acc_next;
  logic [31:0] declared_next;
  logic [31:0] finished_next;
  status_t     status_next;

  kind_t       kind_c;
  logic [31:0] entry_c;
  logic        complete_c;

  logic        accept;
  logic [32:0] size_ext;
  logic [32:0] next_pos;
  logic [31:0] byte_shifted;
  logic [31:0] len_merged;
  logic [31:0] decl_merged;
  logic [31:0] field_inc;
  logic [31:0] finished_inc;
  logic        past_end;
  logic        no_room_len;
  logic        len_overrun;
  logic        hdr_all_done;
  logic        ent_all_done;

  // The input side is free whenever the result register can take a word.
  assign pack_in.ready = !result_valid || result_out.ready;
  assign accept        = pack_in.valid && pack_in.ready;

  always_comb begin
    if (pack_in.start_of_pack) begin
      phase_cur      = PH_HEADER;
      field_cnt_cur  = '0;
      len_acc_cur    = '0;
      stream_pos_cur = '0;
      declared_cur   = '0;
      finished_cur   = '0;
      status_cur     = ST_PARSING;
    end else begin
      phase_cur      = phase_q;
      field_cnt_cur  = field_cnt_q;
      len_acc_cur    = len_acc_q;
      stream_pos_cur = stream_pos_q;
      declared_cur   = declared_q;
      finished_cur   = finished_q;
      status_cur     = status_q;
    end

    size_ext     = {1'b0, pack_size};
    next_pos     = {1'b0, stream_pos_cur} + 33'd1;
    // Little-endian fields: byte lane is the low two bits of the field count,
    // which also holds for the version and count words of the header.
    byte_shifted = 32'(pack_in.pack_byte) << {field_cnt_cur[1:0], 3'b000};
    len_merged   = len_acc_cur | byte_shifted;
    decl_merged  = declared_cur | byte_shifted;
    field_inc    = field_cnt_cur + 32'd1;
    finished_inc = finished_cur + 32'd1;

    // Entry boundary and length checks against the configured image size.
    past_end     = next_pos >= size_ext;
    no_room_len  = (next_pos + 33'(LenBytes)) > size_ext;
    len_overrun  = (next_pos + {1'b0, len_merged}) > size_ext;
    hdr_all_done = (finished_cur == decl_merged) || past_end;
    ent_all_done = (finished_inc == declared_cur) || past_end;

    phase_next     = phase_cur;
    field_cnt_next = field_cnt_cur;
    len_acc_next   = len_acc_cur;
    declared_next  = declared_cur;
    finished_next  = finished_cur;
    status_next    = status_cur;
    kind_c         = KIND_IGNORED;
    entry_c        = finished_cur;
    complete_c     = 1'b0;

    case (phase_cur)
      PH_HEADER: begin
        kind_c         = KIND_LENGTH;
        entry_c        = '0;
        field_cnt_next = field_inc;
        if ((field_cnt_cur == '0) && (pack_size < 32'(HeaderBytes))) begin
          status_next = ST_TRUNCATED;
          phase_next  = PH_END;
        end else if (field_cnt_cur < 32'd4) begin
          if (pack_in.pack_byte != magic_byte(field_cnt_cur[1:0])) begin
            status_next = ST_BAD_MAGIC;
            phase_next  = PH_END;
          end
        end else if (field_cnt_cur < 32'd8) begin
          len_acc_next = len_merged;
          if ((field_cnt_cur == 32'd7) && (len_merged != GoodVersion)) begin
            status_next = ST_BAD_VERSION;
            phase_next  = PH_END;
          end
        end else begin
          declared_next = decl_merged;
          if (field_cnt_cur >= 32'(HeaderBytes - 1)) begin
            if (hdr_all_done) begin
              status_next = ST_DONE;
              phase_next  = PH_END;
            end else if (no_room_len) begin
              status_next = ST_TRUNCATED;
              phase_next  = PH_END;
            end else begin
              phase_next     = PH_NAMELEN;
              field_cnt_next = '0;
              len_acc_next   = '0;
            end
          end
        end
      end
      PH_NAMELEN, PH_DATALEN: begin
        kind_c         = KIND_LENGTH;
        len_acc_next   = len_merged;
        field_cnt_next = field_inc;
        if (field_inc >= 32'(LenBytes)) begin
          if (len_overrun) begin
            status_next = ST_TRUNCATED;
            phase_next  = PH_END;
          end else if (phase_cur == PH_NAMELEN) begin
            if (len_merged == '0) begin
              if (no_room_len) begin
                status_next = ST_TRUNCATED;
                phase_next  = PH_END;
              end else begin
                phase_next     = PH_DATALEN;
                field_cnt_next = '0;
                len_acc_next   = '0;
              end
            end else begin
              phase_next     = PH_NAME;
              field_cnt_next = '0;
            end
          end else if (len_merged == '0) begin
            // An empty data field completes the entry on its last length byte.
            complete_c    = 1'b1;
            finished_next = finished_inc;
            if (ent_all_done) begin
              status_next = ST_DONE;
              phase_next  = PH_END;
            end else if (no_room_len) begin
              status_next = ST_TRUNCATED;
              phase_next  = PH_END;
            end else begin
              phase_next     = PH_NAMELEN;
              field_cnt_next = '0;
              len_acc_next   = '0;
            end
          end else begin
            phase_next     = PH_DATA;
            field_cnt_next = '0;
          end
        end
      end
      PH_NAME: begin
        kind_c         = KIND_NAME;
        field_cnt_next = field_inc;
        if (field_inc >= len_acc_cur) begin
          if (no_room_len) begin
            status_next = ST_TRUNCATED;
            phase_next  = PH_END;
          end else begin
            phase_next     = PH_DATALEN;
            field_cnt_next = '0;
            len_acc_next   = '0;
          end
        end
      end
      PH_DATA: begin
        kind_c         = KIND_DATA;
        field_cnt_next = field_inc;
        if (field_inc >= len_acc_cur) begin
          complete_c    = 1'b1;
          finished_next = finished_inc;
          if (ent_all_done) begin
            status_next = ST_DONE;
            phase_next  = PH_END;
          end else if (no_room_len) begin
            status_next = ST_TRUNCATED;
            phase_next  = PH_END;
          end else begin
            phase_next     = PH_NAMELEN;
            field_cnt_next = '0;
            len_acc_next   = '0;
          end
        end
      end
      default: begin
        kind_c = KIND_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_q      <= PH_HEADER;
      field_cnt_q  <= '0;
      len_acc_q    <= '0;
      stream_pos_q <= '0;
      declared_q   <= '0;
      finished_q   <= '0;
      status_q     <= ST_PARSING;
      pack_size    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        pack_size <= cfg_wr_data;
      end
      if (accept) begin
        phase_q      <= phase_next;
        field_cnt_q  <= field_cnt_next;
        len_acc_q    <= len_acc_next;
        stream_pos_q <= next_pos[31:0];
        declared_q   <= declared_next;
        finished_q   <= finished_next;
        status_q     <= status_next;
        result_valid <= 1'b1;
      end else if (result_out.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by result_valid.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_kind     <= kind_c;
      res_byte     <= pack_in.pack_byte;
      res_entry    <= entry_c;
      res_complete <= complete_c;
      res_status   <= status_next;
    end
  end

  assign result_out.valid          = result_valid;
  assign result_out.byte_kind      = res_kind;
  assign result_out.payload_byte   = res_byte;
  assign result_out.entry_number   = res_entry;
  assign result_out.entry_complete = res_complete;
  assign result_out.parse_status   = res_status;

  // The parser has stopped exactly when a final status has been recorded.
  a_end_matches_status: assert property (@(posedge clk) disable iff (rst)
    (phase_q == PH_END) == (status_q != ST_PARSING))
    else $error("parse phase and sticky status disagree");

  // Entries can never be finished beyond the declared count.
  a_finished_bounded: assert property (@(posedge clk) disable iff (rst)
    finished_q <= declared_q)
    else $error("more entries finished than declared");

  // An accepted word always lands in the result register.
  a_accept_loads_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted word was not registered");

  // Only a data byte or a data-length byte can complete an entry.
  a_complete_kind: assert property (@(posedge clk) disable iff (rst)
    (result_valid && res_complete) |->
      (res_kind == KIND_DATA || res_kind == KIND_LENGTH))
    else $error("entry completed on a name or ignored byte");

endmodule

// File: tb/lppd_tag_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_tag_checker
// Watches the deframer channels, predicts every tagged word and compares.
// ----------------------------------------------------------------------------
// Each byte word accepted on the input channel is run through a local model
// of the pack parser and the resulting tag is queued. Each word accepted on
// the result channel is compared, field by field, with the oldest tag.
// ----------------------------------------------------------------------------
module lppd_tag_checker
  import lppd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_sop,
  input  logic        out_valid,
  input  logic        out_ready,
  input  kind_t       out_kind,
  input  logic [7:0]  out_payload,
  input  logic [31:0] out_entry,
  input  logic        out_complete,
  input  status_t     out_status,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  output int          fail_total,
  output int          pending_words
);

  typedef enum logic [2:0] {
    SEC_HEADER,
    SEC_NAME_LEN,
    SEC_NAME,
    SEC_DATA_LEN,
    SEC_DATA,
    SEC_STOPPED
  } section_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload;
    logic [31:0] entry;
    logic        complete;
    status_t     status;
  } byte_tag_t;

  // The magic P, M, S, H with the first stream byte in the low lane.
  localparam logic [31:0] PackMagic = 32'h4853_4D50;

  section_t    section;
  logic [31:0] field_count;
  logic [31:0] length_acc;
  logic [31:0] position;
  logic [31:0] entries_declared;
  logic [31:0] entries_done;
  status_t     status;
  logic [31:0] image_size;

  byte_tag_t   expected_tags[$];
  int          fails;

  task automatic restart_pack();
    section          = SEC_HEADER;
    field_count      = '0;
    length_acc       = '0;
    position         = '0;
    entries_declared = '0;
    entries_done     = '0;
    status           = ST_PARSING;
  endtask

  task automatic halt(input status_t why);
    status  = why;
    section = SEC_STOPPED;
  endtask

  // Decides what follows a finished entry or the header.
  task automatic close_entry(input logic [33:0] next);
    if (entries_done == entries_declared || next >= {2'b0, image_size})
      halt(ST_DONE);
    else if (next + 34'(LenBytes) > {2'b0, image_size})
      halt(ST_TRUNCATED);
    else begin
      section     = SEC_NAME_LEN;
      field_count = '0;
      length_acc  = '0;
    end
  endtask

  task automatic close_name(input logic [33:0] next);
    if (next + 34'(LenBytes) > {2'b0, image_size})
      halt(ST_TRUNCATED);
    else begin
      section     = SEC_DATA_LEN;
      field_count = '0;
      length_acc  = '0;
    end
  endtask

  task automatic tag_byte(input logic [7:0] b, input logic sop, output byte_tag_t t);
    logic [33:0] next;
    logic [31:0] k;
    if (sop)
      restart_pack();
    next       = {2'b0, position} + 34'd1;
    t.kind     = KIND_IGNORED;
    t.payload  = b;
    t.entry    = entries_done;
    t.complete = 1'b0;
    case (section)
      SEC_HEADER: begin
        t.kind      = KIND_LENGTH;
        t.entry     = '0;
        k           = field_count;
        field_count = k + 1;
        if (k == 0 && image_size < HeaderBytes)
          halt(ST_TRUNCATED);
        else if (k < 4) begin
          if (b != PackMagic[8 * k[1:0] +: 8])
            halt(ST_BAD_MAGIC);
        end else if (k < 8) begin
          length_acc = length_acc | ({24'b0, b} << (8 * (k - 4)));
          if (k == 7 && length_acc != GoodVersion)
            halt(ST_BAD_VERSION);
        end else begin
          entries_declared = entries_declared | ({24'b0, b} << (8 * (k - 8)));
          if (k >= HeaderBytes - 1)
            close_entry(next);
        end
      end
      SEC_NAME_LEN, SEC_DATA_LEN: begin
        t.kind      = KIND_LENGTH;
        length_acc  = length_acc | ({24'b0, b} << (8 * field_count[1:0]));
        field_count = field_count + 1;
        if (field_count >= LenBytes) begin
          if (next + {2'b0, length_acc} > {2'b0, image_size})
            halt(ST_TRUNCATED);
          else if (section == SEC_NAME_LEN) begin
            if (length_acc == 0)
              close_name(next);
            else begin
              section     = SEC_NAME;
              field_count = '0;
            end
          end else if (length_acc == 0) begin
            t.complete   = 1'b1;
            entries_done = entries_done + 1;
            close_entry(next);
          end else begin
            section     = SEC_DATA;
            field_count = '0;
          end
        end
      end
      SEC_NAME: begin
        t.kind      = KIND_NAME;
        field_count = field_count + 1;
        if (field_count >= length_acc)
          close_name(next);
      end
      SEC_DATA: begin
        t.kind      = KIND_DATA;
        field_count = field_count + 1;
        if (field_count >= length_acc) begin
          t.complete   = 1'b1;
          entries_done = entries_done + 1;
          close_entry(next);
        end
      end
      default: begin
      end
    endcase
    position = position + 1;
    t.status = status;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t ns: result word %s is %0h, expected %0h", $time, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin : watch
    byte_tag_t want;
    if (rst) begin
      restart_pack();
      image_size = '0;
      expected_tags.delete();
    end else begin
      if (in_valid && in_ready) begin
        tag_byte(in_byte, in_sop, want);
        expected_tags.insert(expected_tags.size(), want);
      end
      if (out_valid && out_ready) begin
        if (expected_tags.size() == 0)
          flag_mismatch("with nothing outstanding, byte", 32'(out_payload), 32'h0);
        else begin
          want = expected_tags.pop_front();
          if (out_kind != want.kind)
            flag_mismatch("byte_kind", 32'(out_kind), 32'(want.kind));
          if (out_payload != want.payload)
            flag_mismatch("payload_byte", 32'(out_payload), 32'(want.payload));
          if (out_entry != want.entry)
            flag_mismatch("entry_number", out_entry, want.entry);
          if (out_complete != want.complete)
            flag_mismatch("entry_complete", 32'(out_complete), 32'(want.complete));
          if (out_status != want.status)
            flag_mismatch("parse_status", 32'(out_status), 32'(want.status));
        end
      end
      // The register is sampled live, so the word accepted at this edge
      // still sees the old size.
      if (cfg_wr_en)
        image_size = cfg_wr_data;
    end
    fail_total    <= fails;
    pending_words <= expected_tags.size();
  end

endmodule

// File: tb/length_prefixed_pack_deframer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_pack_deframer_core_test
// Stimulus and verdict for the length-prefixed pack deframer.
// ----------------------------------------------------------------------------
// A short directed run covers the short image, bad magic, bad version and a
// pack with no entries. The bulk of the run then walks through a series of
// pack sizes, from zero to the full 32-bit range, and feeds mostly well-formed
// packs with random names and data, mixed with corrupted headers, overlong
// lengths, cut-off packs and stray trailing bytes. A separate checker predicts
// every result word and counts mismatches; this module only drives the block
// and reports the outcome.
// ----------------------------------------------------------------------------
module length_prefixed_pack_deframer_core_test;
  import lppd_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int ItemTarget   = 1050;
  localparam int QuietFrom    = 880;   // words sent after which nobody idles
  localparam int HoldPhase    = 1;     // phase in which the receiver holds off
  localparam int HoldCycles   = 120;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  int fail_total;
  int pending_words;
  int sent_words = 0;
  int cycle_count = 0;

  // Pacing controls shared between the sender and the receiver process.
  bit sender_idles;
  bit sink_stalls;
  bit long_hold_wanted;
  bit long_hold_served;

  // Image under construction, sent one byte per word.
  logic [7:0] img[$];

  lppd_in_if  pack_ch ();
  lppd_out_if result_ch ();

  length_prefixed_pack_deframer_core dut (
    .clk        (clk),
    .rst        (rst),
    .pack_in    (pack_ch),
    .result_out (result_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lppd_tag_checker tag_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (pack_ch.valid),
    .in_ready     (pack_ch.ready),
    .in_byte      (pack_ch.pack_byte),
    .in_sop       (pack_ch.start_of_pack),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .out_kind     (result_ch.byte_kind),
    .out_payload  (result_ch.payload_byte),
    .out_entry    (result_ch.entry_number),
    .out_complete (result_ch.entry_complete),
    .out_status   (result_ch.parse_status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_total   (fail_total),
    .pending_words(pending_words)
  );

  always #5ns clk = ~clk;

  // Hard stop in case the block wedges; this is far beyond the slowest
  // legal run, even with every gap and stall at its longest.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one byte word and returns at the edge where it is taken. When the
  // sender is allowed to idle, a random gap is sometimes put in front of it.
  // valid is left high after acceptance so that back-to-back words do not
  // lower and raise it in the same step.
  task automatic send_word(input logic [7:0] b, input logic sop);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      pack_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    pack_ch.valid         <= 1'b1;
    pack_ch.pack_byte     <= b;
    pack_ch.start_of_pack <= sop;
    @(posedge clk);
    while (!pack_ch.ready) @(posedge clk);
    sent_words++;
  endtask

  // Sends the first count bytes of the image, marking the first as the
  // start of a pack when asked to.
  task automatic send_image(input int count, input bit first_sop);
    int i;
    for (i = 0; i < count && i < img.size(); i++)
      send_word(img[i], first_sop && i == 0);
  endtask

  // Appends one byte to the image.
  task automatic add_byte(input logic [7:0] v);
    img.insert(img.size(), v);
  endtask

  task automatic put_le32(input logic [31:0] v);
    int i;
    for (i = 0; i < 4; i++)
      add_byte(v[8 * i +: 8]);
  endtask

  // The size register is only touched while the block is idle: the sender
  // drops valid, then waits until every outstanding result word is back.
  // This is also where the sender pauses until nothing is left in flight.
  task automatic set_pack_size(input logic [31:0] v);
    pack_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Builds one pack, mostly well formed. Now and then the magic or version
  // is broken, the entry count disagrees with what follows, a length is
  // absurdly large, stray bytes trail the pack, the pack is cut short, or
  // its first byte is sent without the start mark.
  task automatic emit_pack();
    int          n;
    int          i;
    int          j;
    int          count;
    logic [31:0] declared;
    logic [31:0] version;
    logic [31:0] len;
    img.delete();
    n        = $urandom_range(0, 4);
    declared = n;
    case ($urandom_range(0, 15))
      0:       declared = $urandom;
      1, 2:    declared = n + $urandom_range(1, 3);
      default: declared = n;
    endcase
    version = GoodVersion;
    if ($urandom_range(0, 15) == 0)
      version = version ^ (32'h1 << $urandom_range(0, 31));
    put_le32(32'h4853_4D50);
    if ($urandom_range(0, 15) == 0)
      img[$urandom_range(0, 3)] = 8'($urandom);
    put_le32(version);
    put_le32(declared);
    for (i = 0; i < n; i++) begin
      // Name field then data field; huge lengths only get a few bytes,
      // which is plenty since the parser stops on any that run past pack_size.
      repeat (2) begin
        len = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
          len = 0;
        if ($urandom_range(0, 24) == 0)
          len = $urandom;
        put_le32(len);
        for (j = 0; j < 16 && j < len; j++)
          add_byte(8'($urandom));
      end
    end
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
    count = img.size();
    if ($urandom_range(0, 9) == 0)
      count = $urandom_range(1, img.size() - 1);
    send_image(count, $urandom_range(0, 19) != 0);
  endtask

  // Result side: random stall bursts while stalls are allowed, plain
  // readiness otherwise, and one long hold-off in the chosen phase so the
  // block fills up and has to push back on its input.
  initial begin : sink_pacing
    int n;
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_wanted && !long_hold_served) begin
        result_ch.ready <= 1'b0;
        for (n = 0; n < HoldCycles; n++)
          @(posedge clk);
        long_hold_served = 1'b1;
      end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        result_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int          phase;
    int          pk;
    logic [31:0] size_setting;
    rst                   <= 1'b1;
    cfg_wr_en             <= 1'b0;
    cfg_wr_data           <= '0;
    pack_ch.valid         <= 1'b0;
    pack_ch.pack_byte     <= '0;
    pack_ch.start_of_pack <= 1'b0;
    sender_idles          = 1'b0;
    sink_stalls           <= 1'b0;
    long_hold_wanted      <= 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Straight out of reset the size is zero, so the very
    // first byte is a header byte of an image too short for its header,
    // even without the start mark; a restart changes nothing about that.
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);

    set_pack_size(32'hFFFF_FFFF);
    // Wrong first magic byte.
    send_word(8'h51, 1'b1);
    // Good magic, version 2: rejected on the last version byte.
    img.delete();
    put_le32(32'h4853_4D50);
    put_le32(32'd2);
    send_image(8, 1'b1);
    // A valid pack that declares no entries finishes on its last header
    // byte, and the word after it is ignored.
    img.delete();
    put_le32(32'h4853_4D50);
    put_le32(GoodVersion);
    put_le32(32'd0);
    send_image(12, 1'b1);
    send_word(8'hA5, 1'b0);

    // Random part: one pack size per phase, several packs under each.
    // Sizes cycle through the full range, the exact header size, sizes too
    // short for the header or for a first length field, and sizes close to
    // typical packs so that done-by-size and truncation both turn up often.
    for (phase = 0; sent_words < ItemTarget; phase++) begin
      case (phase % 8)
        0:       size_setting = 32'hFFFF_FFFF;
        1:       size_setting = $urandom_range(12, 90);
        2:       size_setting = 32'd12;
        3:       size_setting = $urandom_range(13, 15);
        4:       size_setting = $urandom_range(20, 60);
        5:       size_setting = 32'h8000_0000 | $urandom;
        6:       size_setting = (phase == 6) ? 32'd0 : $urandom_range(1, 11);
        default: size_setting = $urandom_range(30, 120);
      endcase
      set_pack_size(size_setting);

      if (sent_words >= QuietFrom) begin
        sender_idles = 1'b0;
        sink_stalls  <= 1'b0;
      end else begin
        sender_idles = (phase % 3) != 2;
        sink_stalls  <= (phase % 4) != 3;
      end
      // During the long hold-off the sender keeps offering without gaps.
      if (phase == HoldPhase) begin
        sender_idles = 1'b0;
        long_hold_wanted <= 1'b1;
      end

      for (pk = 0; pk < 4 && sent_words < ItemTarget; pk++)
        emit_pack();
    end

    // Drain: wait for every outstanding word, then a few more cycles in
    // case anything unexpected trails out of the block.
    pack_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    if (fail_total == 0 && pending_words == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: files.f
src/lppd_pkg.sv
src/lppd_in_if.sv
src/lppd_out_if.sv
src/length_prefixed_pack_deframer_core.sv
tb/lppd_tag_checker.sv
tb/length_prefixed_pack_deframer_core_test.sv
